[design/scba_pkg.sv]
package scba_pkg;

    localparam int NUM_CLASSES      = 5;
    localparam int BLOCK_BYTES      = 128;
    localparam int BLOCKS_PER_CLASS = 128;
    localparam int BITS_PER_WORD    = 16;

    localparam int WORDS_PER_CLASS = (BLOCKS_PER_CLASS + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int NUM_WORDS       = NUM_CLASSES * WORDS_PER_CLASS;
    localparam int REGION_BYTES    = NUM_CLASSES * BLOCKS_PER_CLASS * BLOCK_BYTES;
    localparam int MAX_CLASS_BYTES = BLOCK_BYTES << (NUM_CLASSES - 1);

    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int BIT_W       = $clog2(BITS_PER_WORD);
    localparam int WORD_SEL_W  = $clog2(WORDS_PER_CLASS);
    localparam int CLASS_SHIFT = BLOCK_SHIFT + $clog2(BLOCKS_PER_CLASS);
    localparam int CLASS_W     = $clog2(NUM_CLASSES + 1);
    localparam int MEM_AW      = $clog2(NUM_WORDS);
    localparam int COUNT_W     = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [SIZE_W-1:0]        size_t;
    typedef logic [1:0]               status_t;
    typedef logic [BITS_PER_WORD-1:0] word_t;
    typedef logic [CLASS_W-1:0]       class_t;
    typedef logic [WORD_SEL_W-1:0]    word_sel_t;
    typedef logic [BIT_W-1:0]         bit_sel_t;
    typedef logic [COUNT_W-1:0]       count_t;
    typedef logic [MEM_AW-1:0]        mem_addr_t;
    typedef logic [CFG_INDEX_W-1:0]   cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

    localparam status_t ST_DONE      = 2'd0;
    localparam status_t ST_TOO_LARGE = 2'd1;
    localparam status_t ST_NO_SPACE  = 2'd2;
    localparam status_t ST_IGNORED   = 2'd3;

    localparam cfg_index_t CFG_MEM_BASE    = 2'd0;
    localparam cfg_index_t CFG_MAX_REQUEST = 2'd1;

    localparam size_t MAX_REQUEST_RESET = 16'd2048;

    typedef enum logic [1:0] {
        CMD_REPORT,
        CMD_ALLOC,
        CMD_FREE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        status_t   status;
        class_t    cls;
        word_sel_t word;
        bit_sel_t  bit_idx;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_COUNT,
        B_SCAN,
        B_FREE_CHK
    } back_state_t;

    function automatic word_t group_mask(input class_t cls);
        word_t m;
        case (cls)
            3'd0:    m = 16'h0001;
            3'd1:    m = 16'h0003;
            3'd2:    m = 16'h000F;
            3'd3:    m = 16'h00FF;
            3'd4:    m = 16'hFFFF;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic mem_addr_t word_addr(input class_t cls, input word_sel_t word);
        return MEM_AW'(int'(cls) * WORDS_PER_CLASS + int'(word));
    endfunction

endpackage

[design/scba_intf.sv]
interface scba_req_if;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    scba_pkg::size_t      request_size;
    scba_pkg::addr_t      free_address;

    modport source (output valid, mode, request_size, free_address, input ready);
    modport sink   (input valid, mode, request_size, free_address, output ready);
endinterface

interface scba_rsp_if;
    logic                 valid;
    logic                 ready;
    scba_pkg::status_t    status;
    scba_pkg::addr_t      address;

    modport source (output valid, status, address, input ready);
    modport sink   (input valid, status, address, output ready);
endinterface

[design/size_class_bitmap_allocator.sv]
// Channel  Direction  Contents
// req      in         mode, request_size, free_address
// rsp      out        status, address
// cfg      in         cfg_we, cfg_index, cfg_data (write only)
//
// A request passes the front classifier into a two-entry queue.
// The back end answers a rejected request from idle, checks one bitmap word
// for a free, and for an allocation skips empty classes, then scans up to 8
// occupancy words, reading one word per cycle from the bitmap memory.
// Reset marks every block free and loads the free counts; no clearing pass.
// A result waiting on rsp holds the back end; the front keeps filling the queue.
module size_class_bitmap_allocator (
    input  logic                  clk,
    input  logic                  rst_n,
    scba_req_if.sink              req,
    scba_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  scba_pkg::cfg_index_t  cfg_index,
    input  scba_pkg::cfg_data_t   cfg_data
);
    import scba_pkg::*;

    addr_t mem_base_reg;
    size_t max_request_reg;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_not_empty;
    cmd_t  push_cmd;
    cmd_t  head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_base_reg    <= '0;
            max_request_reg <= MAX_REQUEST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MEM_BASE:    mem_base_reg    <= cfg_data;
                CFG_MAX_REQUEST: max_request_reg <= cfg_data[SIZE_W-1:0];
                default:         mem_base_reg    <= mem_base_reg;
            endcase
        end
    end

    scba_front u_front (
        .req         (req),
        .mem_base    (mem_base_reg),
        .max_request (max_request_reg),
        .queue_full  (q_full),
        .push        (q_push),
        .cmd         (push_cmd)
    );

    scba_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .head_cmd  (head_cmd),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    scba_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (q_not_empty),
        .cmd_pop   (q_pop),
        .mem_base  (mem_base_reg),
        .rsp       (rsp)
    );

endmodule

[design/scba_front.sv]
module scba_front (
    scba_req_if.sink        req,
    input  scba_pkg::addr_t mem_base,
    input  scba_pkg::size_t max_request,
    input  logic            queue_full,
    output logic            push,
    output scba_pkg::cmd_t  cmd
);
    import scba_pkg::*;

    addr_t  offset;
    class_t fit_class;

    assign req.ready = !queue_full;
    assign push      = req.valid && !queue_full;
    assign offset    = req.free_address - mem_base;

    // Smallest class whose block group holds the request.
    always_comb
    begin
        fit_class = class_t'(NUM_CLASSES - 1);
        for (int d = NUM_CLASSES - 1; d >= 0; d--)
        begin
            if (32'(req.request_size) <= 32'(BLOCK_BYTES << d))
            begin
                fit_class = class_t'(d);
            end
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.kind    = CMD_REPORT;
        cmd.status  = ST_DONE;
        cmd.cls     = fit_class;
        cmd.word    = offset[BLOCK_SHIFT + BIT_W +: WORD_SEL_W];
        cmd.bit_idx = offset[BLOCK_SHIFT +: BIT_W];
        if (!req.mode)
        begin
            if (req.request_size > max_request)
            begin
                cmd.status = ST_TOO_LARGE;
            end
            else if (32'(req.request_size) > 32'(MAX_CLASS_BYTES))
            begin
                cmd.status = ST_NO_SPACE;
            end
            else
            begin
                cmd.kind = CMD_ALLOC;
            end
        end
        else
        begin
            if (offset >= addr_t'(REGION_BYTES))
            begin
                cmd.status = ST_IGNORED;
            end
            else
            begin
                cmd.kind = CMD_FREE;
                cmd.cls  = offset[CLASS_SHIFT +: CLASS_W];
            end
        end
    end

endmodule

[design/scba_queue.sv]
module scba_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  scba_pkg::cmd_t push_cmd,
    input  logic           pop,
    output scba_pkg::cmd_t head_cmd,
    output logic           not_empty,
    output logic           full
);
    import scba_pkg::*;

    cmd_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/scba_back.sv]
module scba_back (
    input  logic            clk,
    input  logic            rst_n,
    input  scba_pkg::cmd_t  cmd,
    input  logic            cmd_valid,
    output logic            cmd_pop,
    input  scba_pkg::addr_t mem_base,
    scba_rsp_if.source      rsp
);
    import scba_pkg::*;

    back_state_t state_reg, state_next;

    class_t    class_reg, class_next;
    word_sel_t word_reg, word_next;
    bit_sel_t  bit_reg, bit_next;

    word_t            mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] word_valid_reg;
    word_t            rd_data_reg;
    logic             rd_valid_reg;
    mem_addr_t        rd_addr;
    logic             mem_we;
    mem_addr_t        mem_wa;
    word_t            mem_wd;

    count_t           counts_reg [NUM_CLASSES];
    logic             count_we;
    count_t           count_wd;
    count_t           sel_count;

    logic             out_valid_reg;
    status_t          out_status_reg;
    addr_t            out_address_reg;
    logic             out_load;
    status_t          out_status_next;
    addr_t            out_address_next;

    word_t            cur_word;
    word_t            cls_mask;
    bit_sel_t         align_mask;
    logic [BITS_PER_WORD-1:0] free_grp;
    logic             found;
    bit_sel_t         found_pos;
    logic             start;

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.address = out_address_reg;

    // A new request is only taken while the result slot is empty, so every
    // result produced later has a free slot to land in.
    assign start    = (state_reg == B_IDLE) && cmd_valid && !out_valid_reg;
    assign cmd_pop  = start;
    assign cur_word = rd_valid_reg ? rd_data_reg : '0;
    assign cls_mask = group_mask(class_reg);
    assign sel_count = (class_reg < class_t'(NUM_CLASSES)) ?
                       counts_reg[class_reg[CLASS_W-1:0]] : '0;
    assign align_mask = BIT_W'((32'd1 << class_reg) - 32'd1);

    // Free aligned groups in the word just read, lowest position first.
    always_comb
    begin
        found     = 1'b0;
        found_pos = '0;
        for (int j = 0; j < BITS_PER_WORD; j++)
        begin
            free_grp[j] = ((BIT_W'(j) & align_mask) == '0) &&
                          ((cur_word & word_t'(cls_mask << j)) == '0);
        end
        for (int j = BITS_PER_WORD - 1; j >= 0; j--)
        begin
            if (free_grp[j])
            begin
                found     = 1'b1;
                found_pos = BIT_W'(j);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    case (cmd.kind)
                        CMD_ALLOC: state_next = B_COUNT;
                        CMD_FREE:  state_next = B_FREE_CHK;
                        default:   state_next = B_IDLE;
                    endcase
                end
            end
            B_COUNT:
            begin
                if (class_reg >= class_t'(NUM_CLASSES))
                begin
                    state_next = B_IDLE;
                end
                else if (sel_count != '0)
                begin
                    state_next = B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (found || word_reg == word_sel_t'(WORDS_PER_CLASS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_FREE_CHK:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        class_next       = class_reg;
        word_next        = word_reg;
        bit_next         = bit_reg;
        rd_addr          = word_addr(class_reg, word_reg);
        mem_we           = 1'b0;
        mem_wa           = word_addr(class_reg, word_reg);
        mem_wd           = '0;
        count_we         = 1'b0;
        count_wd         = '0;
        out_load         = 1'b0;
        out_status_next  = ST_DONE;
        out_address_next = '0;
        case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    class_next = cmd.cls;
                    word_next  = cmd.word;
                    bit_next   = cmd.bit_idx;
                    rd_addr    = word_addr(cmd.cls, cmd.word);
                    if (cmd.kind == CMD_REPORT)
                    begin
                        out_load        = 1'b1;
                        out_status_next = cmd.status;
                    end
                end
            end
            B_COUNT:
            begin
                word_next = '0;
                rd_addr   = word_addr(class_reg, '0);
                if (class_reg >= class_t'(NUM_CLASSES))
                begin
                    out_load        = 1'b1;
                    out_status_next = ST_NO_SPACE;
                end
                else if (sel_count == '0)
                begin
                    class_next = class_reg + 1'b1;
                end
            end
            B_SCAN:
            begin
                word_next = word_reg + 1'b1;
                rd_addr   = word_addr(class_reg, word_reg + 1'b1);
                if (found)
                begin
                    mem_we           = 1'b1;
                    mem_wd           = cur_word | word_t'(cls_mask << found_pos);
                    count_we         = 1'b1;
                    count_wd         = sel_count - 1'b1;
                    out_load         = 1'b1;
                    out_status_next  = ST_DONE;
                    out_address_next = mem_base +
                        (addr_t'({class_reg, word_reg, found_pos}) << BLOCK_SHIFT);
                end
                else if (word_reg == word_sel_t'(WORDS_PER_CLASS - 1))
                begin
                    out_load        = 1'b1;
                    out_status_next = ST_NO_SPACE;
                end
            end
            B_FREE_CHK:
            begin
                out_load = 1'b1;
                if (!cur_word[bit_reg])
                begin
                    out_status_next = ST_IGNORED;
                end
                else
                begin
                    // The group is cut at the end of its word.
                    mem_we          = 1'b1;
                    mem_wd          = cur_word & ~word_t'(cls_mask << bit_reg);
                    count_we        = 1'b1;
                    count_wd        = sel_count + 1'b1;
                    out_status_next = ST_DONE;
                end
            end
            default:
            begin
                class_next = class_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int d = 0; d < NUM_CLASSES; d++)
            begin
                counts_reg[d] <= COUNT_W'(BLOCKS_PER_CLASS >> d);
            end
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= word_valid_reg[rd_addr];
            if (mem_we)
            begin
                word_valid_reg[mem_wa] <= 1'b1;
            end
            if (count_we)
            begin
                counts_reg[class_reg[CLASS_W-1:0]] <= count_wd;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg   <= class_next;
        word_reg    <= word_next;
        bit_reg     <= bit_next;
        rd_data_reg <= mem[rd_addr];
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (out_load)
        begin
            out_status_reg  <= out_status_next;
            out_address_reg <= out_address_next;
        end
    end

endmodule
